### hdl/ptb_pkg.sv
// Shared types, codes and sizing constants for the periodic task timer bank.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package ptb_pkg;

  // Bank size and derived widths
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KIND_W    = 3;
  localparam int FSLOT_W   = 4;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = SLOT_W + FSLOT_W;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    K_ATTACH = 3'd0,
    K_DETACH = 3'd1,
    K_TICK   = 3'd2,
    K_RTICK  = 3'd3,
    K_EXEC   = 3'd4,
    K_SLEEP  = 3'd5
  } kind_t;

  // Slot modes
  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_SCHED = 2'd1,
    MODE_DET   = 2'd2
  } mode_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BUSY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DETACHED = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

  // Slot memory access
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    logic              cd_we;
    logic              per_we;
    logic              rc_we;
    logic [DATA_W-1:0] cd_wdata;
    logic [DATA_W-1:0] per_wdata;
    logic [DATA_W-1:0] rc_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] cd_q;
    logic [DATA_W-1:0] per_q;
    logic [DATA_W-1:0] rc_q;
  } mem_rsp_t;

  // Shared counter unit
  typedef struct packed {
    logic [DATA_W-1:0] op;
    logic              dec;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

### hdl/ptb_if.sv
// Valid/ready channel interfaces for the item and result beats.
// Depends on ptb_pkg for field widths.
`default_nettype none

interface ptb_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptb_pkg::KIND_W-1:0]   kind;
  logic [ptb_pkg::FSLOT_W-1:0]  slot;
  logic [ptb_pkg::DATA_W-1:0]   value;

  modport source (output valid, kind, slot, value, input ready);
  modport sink   (input valid, kind, slot, value, output ready);
endinterface

interface ptb_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptb_pkg::STATUS_W-1:0] status;
  logic                         fired;
  logic [ptb_pkg::FSLOT_W-1:0]  run_slot;
  logic [ptb_pkg::DATA_W-1:0]   run_time;
  logic                         gets_args;
  logic                         last;

  modport source (output valid, status, fired, run_slot, run_time, gets_args, last,
                  input ready);
  modport sink   (input valid, status, fired, run_slot, run_time, gets_args, last,
                  output ready);
endinterface

`default_nettype wire

### hdl/ptb_slot_mem.sv
// Per-slot countdown, period and run-time storage with registered reads.
// Depends on ptb_pkg for the request and response structs.
`default_nettype none

module ptb_slot_mem (
  input  logic              clk,
  input  ptb_pkg::mem_req_t req,
  output ptb_pkg::mem_rsp_t rsp
);
  import ptb_pkg::*;

  logic [DATA_W-1:0] cd_mem  [NUM_SLOTS];
  logic [DATA_W-1:0] per_mem [NUM_SLOTS];
  logic [DATA_W-1:0] rc_mem  [NUM_SLOTS];

  logic [DATA_W-1:0] cd_q_r, per_q_r, rc_q_r;

  // Write selected fields of one slot
  always_ff @(posedge clk) begin
    if (req.cd_we)  cd_mem[req.wr_addr]  <= req.cd_wdata;
    if (req.per_we) per_mem[req.wr_addr] <= req.per_wdata;
    if (req.rc_we)  rc_mem[req.wr_addr]  <= req.rc_wdata;
  end

  // Read one slot; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      cd_q_r  <= cd_mem[req.rd_addr];
      per_q_r <= per_mem[req.rd_addr];
      rc_q_r  <= rc_mem[req.rd_addr];
    end
  end

  assign rsp.cd_q  = cd_q_r;
  assign rsp.per_q = per_q_r;
  assign rsp.rc_q  = rc_q_r;

endmodule

`default_nettype wire

### hdl/ptb_alu.sv
// Shared 32-bit step unit: increments run time or decrements a countdown.
// Depends on ptb_pkg for the request and response structs.
`default_nettype none

module ptb_alu (
  input  ptb_pkg::alu_req_t req,
  output ptb_pkg::alu_rsp_t rsp
);
  import ptb_pkg::*;

  logic [DATA_W-1:0] step;

  // Add one, or add all ones to count down
  assign step     = req.dec ? {DATA_W{1'b1}} : {{(DATA_W-1){1'b0}}, 1'b1};
  assign rsp.sum  = req.op + step;
  assign rsp.zero = (rsp.sum == '0);

endmodule

`default_nettype wire

### hdl/ptb_ctrl.sv
// Sequencer: walks slots one per cycle unless stalled; applies items, drives beats.
// Depends on ptb_pkg, ptb_if; talks to ptb_slot_mem and ptb_alu through structs.
`default_nettype none

module ptb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  ptb_in_if.sink                      in_bus,
  ptb_out_if.source                   out_bus,
  input  logic [ptb_pkg::FSLOT_W-1:0] target,
  output ptb_pkg::mem_req_t           mem_req,
  input  ptb_pkg::mem_rsp_t           mem_rsp,
  output ptb_pkg::alu_req_t           alu_req,
  input  ptb_pkg::alu_rsp_t           alu_rsp
);
  import ptb_pkg::*;

  // Sequencer state
  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [DATA_W-1:0]   value_r, value_nxt;
  logic                single_r, single_nxt;
  logic                left_r, left_nxt;
  logic                pv_r, pv_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   pidx_r, pidx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  // Slot flags
  mode_t               mode_r   [NUM_SLOTS];
  mode_t               mode_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] ready_r, ready_nxt;

  // Result register
  logic                out_v_r, out_v_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_fired_r, out_fired_nxt;
  logic [FSLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [DATA_W-1:0]   out_time_r, out_time_nxt;
  logic                out_args_r, out_args_nxt;
  logic                out_last_r, out_last_nxt;

  // Decode
  kind_t                in_kind;
  logic [IDX_W-1:0]     in_slot_wide;
  logic                 in_ok;
  logic                 in_single;
  logic                 accept;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] above;
  logic                 is_last;
  mode_t                cur_mode;
  logic                 cur_sched;
  logic                 cur_rdy;
  logic [IDX_W-1:0]     p_wide;
  logic [IDX_W-1:0]     t_wide;
  logic                 emit;
  logic                 can_load;
  logic                 stall;
  logic                 fire;
  logic                 walk_done;

  assign in_kind      = kind_t'(in_bus.kind);
  assign in_slot_wide = {{SLOT_W{1'b0}}, in_bus.slot};
  assign in_ok        = in_slot_wide < IDX_W'(NUM_SLOTS);
  assign in_single    = (in_kind == K_ATTACH) || (in_kind == K_DETACH) ||
                        (in_kind == K_SLEEP);
  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;

  // Ready-and-scheduled mask, and slots above the one in process
  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      mask[j]  = (mode_r[j] == MODE_SCHED) && ready_r[j];
      above[j] = (SLOT_W'(j) > pidx_r);
    end
  end

  assign is_last   = ~|(mask & above);
  assign cur_mode  = mode_r[pidx_r];
  assign cur_sched = (cur_mode == MODE_SCHED);
  assign cur_rdy   = ready_r[pidx_r];
  assign p_wide    = {{FSLOT_W{1'b0}}, pidx_r};
  assign t_wide    = {{SLOT_W{1'b0}}, target};

  assign emit      = (state_r == S_WALK) && pv_r && (kind_r == K_EXEC) &&
                     cur_sched && cur_rdy;
  assign can_load  = !out_v_r || out_bus.ready;
  assign stall     = emit && !can_load;
  assign fire      = (state_r == S_WALK) && pv_r && !stall;
  assign walk_done = (state_r == S_WALK) && !left_r && (!pv_r || fire);

  // Shared unit counts down on tick, up otherwise
  assign alu_req.op  = (kind_r == K_TICK) ? mem_rsp.cd_q : mem_rsp.rc_q;
  assign alu_req.dec = (kind_r == K_TICK);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            K_ATTACH, K_DETACH, K_SLEEP: state_nxt = in_ok ? S_WALK : S_RESP;
            K_TICK, K_RTICK:             state_nxt = S_WALK;
            K_EXEC:                      state_nxt = (|mask) ? S_WALK : S_RESP;
            default:                     state_nxt = S_RESP;
          endcase
        end
      end
      S_WALK: begin
        if (walk_done) state_nxt = (kind_r == K_EXEC) ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        if (can_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Walk control, slot updates and memory requests
  always_comb begin
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    single_nxt = single_r;
    left_nxt   = left_r;
    pv_nxt     = pv_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    ready_nxt  = ready_r;

    mem_req           = '0;
    mem_req.rd_addr   = idx_r;
    mem_req.wr_addr   = pidx_r;

    // Latch a new item
    if (accept) begin
      kind_nxt   = in_kind;
      value_nxt  = in_bus.value;
      single_nxt = in_single;
      left_nxt   = 1'b1;
      pv_nxt     = 1'b0;
      status_nxt = STAT_OK;
      idx_nxt    = in_single ? in_slot_wide[SLOT_W-1:0] : '0;
    end

    // Issue the next slot read
    if ((state_r == S_WALK) && !stall) begin
      if (left_r) begin
        mem_req.rd_en = 1'b1;
        pv_nxt        = 1'b1;
        pidx_nxt      = idx_r;
        if (single_r || (idx_r == SLOT_W'(NUM_SLOTS - 1))) begin
          left_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        pv_nxt = 1'b0;
      end
    end

    // Apply the item to the slot whose data is back
    if (fire) begin
      case (kind_r)
        K_ATTACH: begin
          mem_req.per_we    = 1'b1;
          mem_req.per_wdata = value_r;
          mem_req.cd_we     = 1'b1;
          mem_req.cd_wdata  = value_r;
          mem_req.rc_we     = 1'b1;
          ready_nxt[pidx_r] = 1'b0;
          status_nxt        = cur_sched ? STAT_BUSY : STAT_OK;
          mode_nxt[pidx_r]  = MODE_SCHED;
        end
        K_DETACH: begin
          if (cur_mode == MODE_DET) begin
            status_nxt = STAT_DETACHED;
          end else begin
            if (cur_sched) begin
              ready_nxt[pidx_r] = 1'b0;
              mem_req.cd_we     = 1'b1;
              mem_req.cd_wdata  = mem_rsp.per_q;
            end
            mode_nxt[pidx_r] = MODE_DET;
          end
        end
        K_TICK: begin
          if (cur_sched && (|mem_rsp.cd_q)) begin
            mem_req.cd_we = 1'b1;
            if (alu_rsp.zero) begin
              ready_nxt[pidx_r] = 1'b1;
              mem_req.cd_wdata  = mem_rsp.per_q;
            end else begin
              mem_req.cd_wdata  = alu_rsp.sum;
            end
          end
        end
        K_RTICK: begin
          if (cur_sched && cur_rdy) begin
            mem_req.rc_we    = 1'b1;
            mem_req.rc_wdata = alu_rsp.sum;
          end
        end
        K_EXEC: begin
          if (cur_sched && cur_rdy) begin
            ready_nxt[pidx_r] = 1'b0;
            mem_req.rc_we     = 1'b1;
          end
        end
        K_SLEEP: begin
          mem_req.cd_we    = 1'b1;
          mem_req.cd_wdata = value_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: run notice, closing beat, or drain
  always_comb begin
    out_v_nxt      = out_v_r;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_time_nxt   = out_time_r;
    out_args_nxt   = out_args_r;
    out_last_nxt   = out_last_r;
    if (fire && emit) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = STAT_OK;
      out_fired_nxt  = 1'b1;
      out_slot_nxt   = p_wide[FSLOT_W-1:0];
      out_time_nxt   = mem_rsp.rc_q;
      out_args_nxt   = (p_wide == t_wide);
      out_last_nxt   = is_last;
    end else if ((state_r == S_RESP) && can_load) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = status_r;
      out_fired_nxt  = 1'b0;
      out_slot_nxt   = '0;
      out_time_nxt   = '0;
      out_args_nxt   = 1'b0;
      out_last_nxt   = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.status    = out_status_r;
  assign out_bus.fired     = out_fired_r;
  assign out_bus.run_slot  = out_slot_r;
  assign out_bus.run_time  = out_time_r;
  assign out_bus.gets_args = out_args_r;
  assign out_bus.last      = out_last_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= 1'b0;
      pv_r    <= 1'b0;
      out_v_r <= 1'b0;
      ready_r <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) mode_r[j] <= MODE_FREE;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      pv_r    <= pv_nxt;
      out_v_r <= out_v_nxt;
      ready_r <= ready_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    value_r      <= value_nxt;
    single_r     <= single_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_time_r   <= out_time_nxt;
    out_args_r   <= out_args_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire

### hdl/periodic_task_timer_bank.sv
// Top level of the periodic task timer bank: target register and block wiring.
// Depends on ptb_pkg, ptb_if, ptb_slot_mem, ptb_alu and ptb_ctrl.
//
//   Channel   Direction  Handshake         Payload
//   in_bus    sink       valid/ready       kind, slot, value
//   out_bus   source     valid/ready       status, fired, run_slot, run_time,
//                                          gets_args, last
//   cfg_*     sink       cfg_we            cfg_wdata (target_slot)
//
// Tick and runtime tick walk every slot through one memory read port and one
// shared 32-bit step unit, then send the closing beat. Exec with a ready slot
// walks too. Exec with nothing ready and unused kinds go straight to the
// closing beat; attach, detach and sleep visit only their own slot. Reset
// clears the slot modes, ready flags and sequencer; there is no clearing pass.
// A full result register pauses the exec walk.
`default_nettype none

module periodic_task_timer_bank (
  input  logic                        clk,
  input  logic                        rst_n,
  ptb_in_if.sink                      in_bus,
  ptb_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [ptb_pkg::FSLOT_W-1:0] cfg_wdata
);
  import ptb_pkg::*;

  logic [FSLOT_W-1:0] target_r;
  mem_req_t           mem_req;
  mem_rsp_t           mem_rsp;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  // Hold the target slot register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  ptb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .target  (target_r),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  ptb_slot_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  ptb_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

`default_nettype wire

### hdl/ptb_checker.sv
// Port-level checks for the periodic task timer bank, bound to the top level.
// Depends on ptb_pkg for widths; attaches through the bind at the end.
`default_nettype none

module ptb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ptb_pkg::STATUS_W-1:0] status,
  input logic                         fired,
  input logic [ptb_pkg::FSLOT_W-1:0]  run_slot,
  input logic [ptb_pkg::DATA_W-1:0]   run_time,
  input logic                         gets_args,
  input logic                         last,
  input logic                         cfg_we,
  input logic [ptb_pkg::FSLOT_W-1:0]  cfg_wdata
);
  import ptb_pkg::*;

  logic [FSLOT_W-1:0] tgt_r;

  // Track the last target written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (cfg_we) begin
      tgt_r <= cfg_wdata;
    end
  end

  // Leave reset idle and empty
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Busy after taking an item
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fired) &&
      $stable(run_slot) && $stable(run_time) && $stable(gets_args) && $stable(last))
    else $error("result beat changed while stalled");

  // Argument flag follows the target register
  a_args_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> gets_args == (fired && (run_slot == tgt_r)))
    else $error("gets_args does not match target slot");

endmodule

bind periodic_task_timer_bank ptb_checker u_ptb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .status    (out_bus.status),
  .fired     (out_bus.fired),
  .run_slot  (out_bus.run_slot),
  .run_time  (out_bus.run_time),
  .gets_args (out_bus.gets_args),
  .last      (out_bus.last),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);

`default_nettype wire

### tb/tb_periodic_task_timer_bank.sv
// Self-checking testbench for periodic_task_timer_bank: directed table, then random phases.
// A local slot-bank predictor checks every result beat. Depends on ptb_pkg, ptb_if and the RTL.
`default_nettype none

module tb_periodic_task_timer_bank;
  import ptb_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int DRAIN_CYCLES  = NUM_SLOTS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 36;
  localparam int IDLE_PCT      = 11;
  localparam int DIR_ROWS      = 24;

  // Kind codes the block leaves unused
  localparam logic [KIND_W-1:0] K_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [FSLOT_W-1:0]  run_slot;
    logic [DATA_W-1:0]   run_time;
    logic                gets_args;
    logic                last;
  } result_t;

  typedef struct packed {
    bit      typed;
    result_t res;
  } tag_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FSLOT_W-1:0]  slot;
    logic [DATA_W-1:0]   value;
    bit                  typed;
    logic [STATUS_W-1:0] status;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FSLOT_W-1:0] cfg_wdata;

  ptb_in_if  in_ch ();
  ptb_out_if out_ch ();

  periodic_task_timer_bank i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted bank state
  mode_t              bank_mode   [NUM_SLOTS];
  logic [DATA_W-1:0]  bank_cd     [NUM_SLOTS];
  logic [DATA_W-1:0]  bank_period [NUM_SLOTS];
  logic               bank_ready  [NUM_SLOTS];
  logic [DATA_W-1:0]  bank_runtime[NUM_SLOTS];
  logic [FSLOT_W-1:0] bank_target;

  result_t pending_results[$];
  tag_t    row_tags[$];

  int  errors;
  int  items_sent;
  int  beats_checked;
  int  beats_in_item;
  int  multi_execs;
  int  largest_burst;
  int  target_writes;
  int  quiet_cycles;
  int  hold_reqs;
  bit  tx_idle_en;
  bit  rx_idle_en;

  // Directed rows; status typed in where it is obvious, exec bursts left to the predictor
  row_t dir_rows [0:DIR_ROWS-1] = '{
    '{K_EXEC,    4'd0,  32'd0,          1'b1, STAT_OK},        // exec with nothing ready
    '{K_DETACH,  4'd3,  32'd0,          1'b1, STAT_OK},        // detach a free slot
    '{K_DETACH,  4'd3,  32'd0,          1'b1, STAT_DETACHED},  // detach twice
    '{K_ATTACH,  4'd0,  32'd1,          1'b1, STAT_OK},
    '{K_ATTACH,  4'd0,  32'd1,          1'b1, STAT_BUSY},      // attach twice
    '{K_ATTACH,  4'd15, 32'hFFFF_FFFF,  1'b1, STAT_OK},        // longest period
    '{K_ATTACH,  4'd3,  32'd2,          1'b1, STAT_OK},        // reattach detached slot
    '{K_ATTACH,  4'd5,  32'd0,          1'b1, STAT_OK},        // zero period never runs
    '{K_TICK,    4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_RTICK,   4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_RTICK,   4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_TICK,    4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_RTICK,   4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_EXEC,    4'd0,  32'd0,          1'b0, STAT_OK},        // two slots ready
    '{K_SLEEP,   4'd15, 32'd1,          1'b1, STAT_OK},
    '{K_TICK,    4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_SLEEP,   4'd0,  32'd0,          1'b1, STAT_OK},        // stop a countdown
    '{K_TICK,    4'd0,  32'd0,          1'b1, STAT_OK},
    '{K_DETACH,  4'd3,  32'd0,          1'b1, STAT_OK},        // detach a scheduled slot
    '{K_SPARE_A, 4'd9,  32'h5A5A_5A5A,  1'b1, STAT_OK},
    '{K_SPARE_B, 4'd15, 32'hFFFF_FFFF,  1'b1, STAT_OK},
    '{K_SLEEP,   4'd3,  32'd5,          1'b1, STAT_OK},        // sleep on a detached slot
    '{K_EXEC,    4'd0,  32'd0,          1'b0, STAT_OK},
    '{K_DETACH,  4'd15, 32'd0,          1'b1, STAT_OK}
  };

  // Clock
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Advance the predicted bank by one item and queue the beats it causes
  task automatic step_bank(input logic [KIND_W-1:0] kind, input logic [FSLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] value, input tag_t tg);
    result_t beats[$];
    result_t r;
    logic [STATUS_W-1:0] status;
    status = STAT_OK;
    r = '0;
    case (kind)
      K_ATTACH: begin
        if (slot < NUM_SLOTS) begin
          bank_period[slot]  = value;
          bank_cd[slot]      = value;
          bank_ready[slot]   = 1'b0;
          bank_runtime[slot] = '0;
          if (bank_mode[slot] == MODE_SCHED) status = STAT_BUSY;
          bank_mode[slot] = MODE_SCHED;
        end
      end
      K_DETACH: begin
        if (slot < NUM_SLOTS) begin
          if (bank_mode[slot] == MODE_DET) begin
            status = STAT_DETACHED;
          end else begin
            if (bank_mode[slot] == MODE_SCHED) begin
              bank_ready[slot] = 1'b0;
              bank_cd[slot]    = bank_period[slot];
            end
            bank_mode[slot] = MODE_DET;
          end
        end
      end
      K_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_mode[i] == MODE_SCHED && bank_cd[i] != 0) begin
            bank_cd[i] = bank_cd[i] - 1;
            if (bank_cd[i] == 0) begin
              bank_ready[i] = 1'b1;
              bank_cd[i]    = bank_period[i];
            end
          end
        end
      end
      K_RTICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_mode[i] == MODE_SCHED && bank_ready[i]) bank_runtime[i] = bank_runtime[i] + 1;
        end
      end
      K_EXEC: begin
        // Report ready slots in ascending order, then clear them
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_mode[i] == MODE_SCHED && bank_ready[i]) begin
            r           = '0;
            r.fired     = 1'b1;
            r.run_slot  = FSLOT_W'(i);
            r.run_time  = bank_runtime[i];
            r.gets_args = (FSLOT_W'(i) == bank_target);
            beats.push_back(r);
            bank_ready[i]   = 1'b0;
            bank_runtime[i] = '0;
          end
        end
      end
      K_SLEEP: begin
        if (slot < NUM_SLOTS) bank_cd[slot] = value;
      end
      default: ;
    endcase
    if (beats.size() == 0) begin
      r        = '0;
      r.status = status;
      beats.push_back(r);
    end
    beats[beats.size()-1].last = 1'b1;
    if (tg.typed) begin
      pending_results.push_back(tg.res);
    end else begin
      foreach (beats[j]) pending_results.push_back(beats[j]);
    end
  endtask

  // Offer one item beat and hold it until accepted
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [FSLOT_W-1:0] s,
                           input logic [DATA_W-1:0] v, input bit typed,
                           input logic [STATUS_W-1:0] st);
    tag_t tg;
    tg            = '0;
    tg.typed      = typed;
    tg.res.status = st;
    tg.res.last   = 1'b1;
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_tags.push_back(tg);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.slot  <= s;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until the bank is idle, then write the target slot register
  task automatic write_target(input logic [FSLOT_W-1:0] tgt);
    in_ch.valid <= 1'b0;
    // Let the monitor predict the last accepted item first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= tgt;
    @(posedge clk);
    cfg_we      <= 1'b0;
    bank_target  = tgt;
    target_writes++;
  endtask

  // Result sink: random idling, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != hold_seen) begin
        hold_seen     = hold_reqs;
        hold_left     = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Predict on each accepted item beat, check each accepted result beat
  always @(posedge clk) begin : beat_monitor
    tag_t    tg;
    result_t want;
    quiet_cycles++;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        tg = '0;
        if (row_tags.size() != 0) tg = row_tags.pop_front();
        step_bank(in_ch.kind, in_ch.slot, in_ch.value, tg);
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        beats_checked++;
        if (pending_results.size() == 0) begin
          log_error("result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            log_error($sformatf("status got %0d want %0d", out_ch.status, want.status));
          if (out_ch.fired !== want.fired)
            log_error($sformatf("fired got %0b want %0b", out_ch.fired, want.fired));
          if (out_ch.run_slot !== want.run_slot)
            log_error($sformatf("run_slot got %0d want %0d", out_ch.run_slot, want.run_slot));
          if (out_ch.run_time !== want.run_time)
            log_error($sformatf("run_time got %0d want %0d", out_ch.run_time, want.run_time));
          if (out_ch.gets_args !== want.gets_args)
            log_error($sformatf("gets_args got %0b want %0b", out_ch.gets_args,
                                want.gets_args));
          if (out_ch.last !== want.last)
            log_error($sformatf("last got %0b want %0b", out_ch.last, want.last));
        end
        // Track exec burst sizes
        beats_in_item++;
        if (out_ch.last === 1'b1) begin
          if (beats_in_item > 1) multi_execs++;
          if (beats_in_item > largest_burst) largest_burst = beats_in_item;
          beats_in_item = 0;
        end
      end
    end
  end

  // Watchdog: too long without any accepted beat
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [KIND_W-1:0]  k;
    logic [FSLOT_W-1:0] s;
    logic [DATA_W-1:0]  v;
    int                 pick;
    errors        = 0;
    items_sent    = 0;
    beats_checked = 0;
    beats_in_item = 0;
    multi_execs   = 0;
    largest_burst = 0;
    target_writes = 0;
    quiet_cycles  = 0;
    hold_reqs     = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      bank_mode[i]    = MODE_FREE;
      bank_cd[i]      = '0;
      bank_period[i]  = '0;
      bank_ready[i]   = 1'b0;
      bank_runtime[i] = '0;
    end
    bank_target = '0;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= '0;
    in_ch.slot  <= '0;
    in_ch.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].value,
                dir_rows[r].typed, dir_rows[r].status);
    end

    // Random phases, each behind a target slot write
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 3:    write_target(4'd15);
        1, 5:    write_target(4'd0);
        default: write_target(FSLOT_W'($urandom_range(NUM_SLOTS - 1)));
      endcase
      // Phase one runs without idling on either side
      tx_idle_en = (p != 1);
      rx_idle_en = (p != 1);
      if (p == 2) hold_reqs++;
      if (p == 3) begin
        // Fill the whole bank so one exec reports every slot
        for (int i = 0; i < NUM_SLOTS; i++) send_item(K_ATTACH, FSLOT_W'(i), 32'd1, 1'b0, STAT_OK);
        send_item(K_TICK, '0, '0, 1'b0, STAT_OK);
        repeat ($urandom_range(3)) send_item(K_RTICK, '0, '0, 1'b0, STAT_OK);
        send_item(K_EXEC, '0, '0, 1'b0, STAT_OK);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        s    = FSLOT_W'($urandom());
        v    = '0;
        if (pick < 15) begin
          k    = K_ATTACH;
          pick = $urandom_range(99);
          if (pick < 70)      v = $urandom_range(1, 4);
          else if (pick < 80) v = '0;
          else if (pick < 92) v = $urandom();
          else                v = '1;
        end else if (pick < 23) begin
          k = K_DETACH;
          v = $urandom();
        end else if (pick < 53) begin
          k = K_TICK;
          v = $urandom();
        end else if (pick < 68) begin
          k = K_RTICK;
          v = $urandom();
        end else if (pick < 88) begin
          k = K_EXEC;
          v = $urandom();
        end else if (pick < 96) begin
          k    = K_SLEEP;
          pick = $urandom_range(99);
          if (pick < 60)      v = $urandom_range(1, 3);
          else if (pick < 80) v = '0;
          else                v = $urandom();
        end else begin
          k = pick[0] ? K_SPARE_A : K_SPARE_B;
          v = $urandom();
        end
        send_item(k, s, v, 1'b0, STAT_OK);
      end
    end

    // Drain and finish
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items and %0d result beats over %0d target slot settings;",
             items_sent, beats_checked, target_writes + 1);
    $display("%0d exec items reported several slots, the largest burst being %0d beats.",
             multi_execs, largest_burst);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
